@@ hdl/affine_transform_accumulator_core_macros.svh @@
// Assertion macros of the transform accumulator RTL.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge, masked while reset is high.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every clock edge, also during reset.
`define ATA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATA_ASSERT(lbl, prop, msg)
`define ATA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/ata_pkg.sv @@
// Types and constants of the transform accumulator.
package ata_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int DATA_W            = 32;
  localparam int ENTRIES           = 16;
  localparam int IDX_W             = 4;

  typedef enum logic [1:0] {
    OP_CLEAR     = 2'd0,
    OP_IDENTITY  = 2'd1,
    OP_TRANSLATE = 2'd2,
    OP_SCALE     = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
    logic signed [DATA_W-1:0] z_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               row_index;
    logic [1:0]               col_index;
    logic signed [DATA_W-1:0] entry_value;
    logic                     last_entry;
  } entry_t;

  // Control that travels with one entry through the update pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    op_t              op;
  } stage_ctl_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

@@ hdl/ata_stream_if.sv @@
// Valid/ready stream channel with a typed payload.
interface ata_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ata_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ata_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ hdl/ata_update_unit.sv @@
// Multiply stage and shift/add/saturate logic that computes one new entry.
module ata_update_unit #(
  parameter int FRACTION_BITS = ata_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  ata_pkg::stage_ctl_t                in_ctl,
  input  logic signed [ata_pkg::DATA_W-1:0]  cur,
  input  logic signed [ata_pkg::DATA_W-1:0]  coef,
  input  logic signed [ata_pkg::DATA_W-1:0]  base,
  output ata_pkg::stage_ctl_t                out_ctl,
  output logic signed [ata_pkg::DATA_W-1:0]  result
);
  import ata_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRACTION_BITS);

  logic signed [DATA_W-1:0] cur_q;
  logic signed [63:0]       prod_q;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [63:0]       shifted;
  logic signed [64:0]       sum;

  // Translate scales the row-3 entry of the same column; scale uses the entry itself.
  assign mul_b = (in_ctl.op == OP_TRANSLATE) ? base : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '{valid: 1'b0, idx: '0, op: OP_CLEAR};
    end else if (en) begin
      out_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cur_q  <= cur;
      prod_q <= 64'(coef) * 64'(mul_b);
    end
  end

  assign shifted = prod_q >>> FRACTION_BITS;
  assign sum     = 65'(cur_q) + 65'(shifted);

  always_comb begin
    case (out_ctl.op)
      OP_CLEAR: begin
        result = '0;
      end
      OP_IDENTITY: begin
        result = (out_ctl.idx[3:2] == out_ctl.idx[1:0]) ? ONE : '0;
      end
      OP_TRANSLATE: begin
        result = (out_ctl.idx[3:2] == 2'd3) ? cur_q : sat32(sum);
      end
      OP_SCALE: begin
        result = (out_ctl.idx[3:2] == 2'd3) ? cur_q : sat32(65'(shifted));
      end
      default: begin
        result = cur_q;
      end
    endcase
  end
endmodule

@@ hdl/affine_transform_accumulator_core.sv @@
// Top level of the 4x4 Q16.16 transform accumulator.
//
// cmd_ch (sink) takes one operation per transaction: opcode (clear, identity,
// translate, scale) and x, y, z values in signed fixed point. entry_ch
// (source) returns the sixteen matrix entries after the operation, row-major,
// with last_entry set on row 3, column 3.
// The matrix sits in a 16-entry RAM. A sequencer reads one entry per cycle
// while the output is not stalled. The RAM read data feeds the multiply
// register of the update unit, the shift/add/saturate logic finishes the
// entry, and the result is written back and loaded into the output register.
// A new command is not taken before the previous one is through: sixteen
// reads go through the single RAM read port and the shared multiplier, and
// the update pipeline drains before cmd_ch.ready goes high again.
// cmd_ch.ready is high once the sixteenth entry of the previous operation
// has reached the output register.
// When the receiver stalls, the whole read/update pipeline holds and the
// output register keeps its entry until it is taken.
// Reset clears the control state and the per-entry valid bits, so the matrix
// reads as identity right after reset; no clearing pass is needed.
module affine_transform_accumulator_core #(
  parameter int FRACTION_BITS = ata_pkg::FRACTION_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ata_stream_if.sink   cmd_ch,
  ata_stream_if.source entry_ch
);
  import ata_pkg::*;

`include "affine_transform_accumulator_core_macros.svh"

  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(64'd1 << FRACTION_BITS);

  logic                     busy;
  logic                     issuing;
  logic [IDX_W-1:0]         cnt;
  op_t                      op_q;
  logic signed [DATA_W-1:0] t_q [3];
  logic signed [DATA_W-1:0] row3 [4];
  logic [ENTRIES-1:0]       vld;
  logic                     s1_valid;
  logic [IDX_W-1:0]         s1_idx;
  logic                     s1_vld;
  logic                     adv;
  logic                     accept;
  logic                     ram_re;
  logic                     ram_we;
  logic [DATA_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] s1_cur;
  logic signed [DATA_W-1:0] s1_coef;
  stage_ctl_t               s1_ctl;
  stage_ctl_t               s2_ctl;
  logic signed [DATA_W-1:0] s2_result;
  cmd_t                     cmd;
  entry_t                   out_q;
  logic                     out_valid;

  assign cmd    = cmd_ch.payload;
  assign adv    = !out_valid || entry_ch.ready;
  assign accept = cmd_ch.valid && !busy;
  assign ram_re = adv && issuing;
  assign ram_we = adv && s2_ctl.valid;

  assign cmd_ch.ready     = !busy;
  assign entry_ch.valid   = out_valid;
  assign entry_ch.payload = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      issuing  <= 1'b0;
      cnt      <= '0;
      s1_valid <= 1'b0;
      vld      <= '0;
      row3     <= '{32'sd0, 32'sd0, 32'sd0, ONE};
    end else begin
      if (accept) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
        cnt     <= '0;
        // Row 3 only changes on clear and identity.
        if (op_t'(cmd.opcode) == OP_CLEAR) begin
          row3 <= '{32'sd0, 32'sd0, 32'sd0, 32'sd0};
        end else if (op_t'(cmd.opcode) == OP_IDENTITY) begin
          row3 <= '{32'sd0, 32'sd0, 32'sd0, ONE};
        end
      end
      if (adv) begin
        s1_valid <= issuing;
        if (issuing) begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(ENTRIES - 1)) begin
            issuing <= 1'b0;
          end
        end
        if (s2_ctl.valid) begin
          vld[s2_ctl.idx] <= 1'b1;
          if (s2_ctl.idx == IDX_W'(ENTRIES - 1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(cmd.opcode);
      t_q[0] <= cmd.x_value;
      t_q[1] <= cmd.y_value;
      t_q[2] <= cmd.z_value;
    end
    if (ram_re) begin
      s1_idx <= cnt;
      s1_vld <= vld[cnt];
    end
  end

  ata_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s2_ctl.idx),
    .wdata (s2_result),
    .re    (ram_re),
    .raddr (cnt),
    .rdata (ram_rdata)
  );

  // An entry never written since reset still holds its identity value.
  always_comb begin
    if (s1_vld) begin
      s1_cur = ram_rdata;
    end else begin
      s1_cur = (s1_idx[3:2] == s1_idx[1:0]) ? ONE : '0;
    end
    case (s1_idx[3:2])
      2'd0:    s1_coef = t_q[0];
      2'd1:    s1_coef = t_q[1];
      2'd2:    s1_coef = t_q[2];
      default: s1_coef = '0;
    endcase
  end

  assign s1_ctl = '{valid: s1_valid, idx: s1_idx, op: op_q};

  ata_update_unit #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_update (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_ctl  (s1_ctl),
    .cur     (s1_cur),
    .coef    (s1_coef),
    .base    (row3[s1_idx[1:0]]),
    .out_ctl (s2_ctl),
    .result  (s2_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      out_q.row_index   <= s2_ctl.idx[3:2];
      out_q.col_index   <= s2_ctl.idx[1:0];
      out_q.entry_value <= s2_result;
      out_q.last_entry  <= (s2_ctl.idx == IDX_W'(ENTRIES - 1));
    end
  end

  `ATA_ASSERT_ALWAYS(a_idle_pipe_empty, !busy |-> (!issuing && !s1_valid && !s2_ctl.valid), "pipeline active while idle")
  `ATA_ASSERT(a_accept_busy, accept |=> (busy && issuing), "accepted command did not start a sweep")
  `ATA_ASSERT(a_write_busy, ram_we |-> busy, "store written outside an operation")
  `ATA_ASSERT(a_stall_hold, (out_valid && !entry_ch.ready) |=> ($stable(s2_ctl) && $stable(cnt)), "pipeline moved during output stall")
  `ATA_ASSERT(a_last_done, (ram_we && s2_ctl.idx == IDX_W'(ENTRIES - 1)) |=> !busy, "busy after the final entry")
endmodule
